### hdl/uuencode_line_encoder_unit_assert.svh
`ifndef UUENCODE_LINE_ENCODER_UNIT_ASSERT_SVH
`define UUENCODE_LINE_ENCODER_UNIT_ASSERT_SVH

// Implication in the same cycle, checked on clk_i, off during reset.
`define ULENC_ASSERT_NOW(lbl, ant, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (cons)) \
    else $error("ulenc assertion failed");

// Implication on the following cycle.
`define ULENC_ASSERT_NEXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (cons)) \
    else $error("ulenc assertion failed");

`endif

### hdl/ulenc_pkg.sv
`timescale 1ns / 1ps
package ulenc_pkg;

  localparam int CNT_W = 6;

  localparam logic [6:0] CH_NL    = 7'd10;
  localparam logic [6:0] CH_SPACE = 7'd32;
  localparam logic [6:0] CH_BQ    = 7'd96;

  typedef struct packed {
    logic             do_line;
    logic             bank;
    logic [CNT_W-1:0] count;
    logic             trailer;
  } ulenc_cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_LEN,
    BK_FETCH,
    BK_EMIT,
    BK_NL,
    BK_TQ,
    BK_TNL
  } bk_state_e;

  function automatic logic [6:0] enc6(input logic [5:0] v);
    logic [6:0] r;
    if (v == 6'd0) begin
      r = CH_BQ;
    end else begin
      r = {1'b0, v} + CH_SPACE;
    end
    return r;
  endfunction

endpackage

### hdl/ulenc_in_if.sv
`timescale 1ns / 1ps
interface ulenc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       carries_byte;
  logic       end_of_message;

  modport source (output valid, data_byte, carries_byte, end_of_message, input ready);
  modport sink   (input valid, data_byte, carries_byte, end_of_message, output ready);
endinterface

### hdl/ulenc_out_if.sv
`timescale 1ns / 1ps
interface ulenc_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] out_char;
  logic       last_of_run;
  logic       message_done;

  modport source (output valid, out_char, last_of_run, message_done, input ready);
  modport sink   (input valid, out_char, last_of_run, message_done, output ready);
endinterface

### hdl/ulenc_ram.sv
`timescale 1ns / 1ps
module ulenc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 90
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

### hdl/ulenc_front.sv
`timescale 1ns / 1ps
module ulenc_front #(
  parameter int LINE_BYTES = 45
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  ulenc_in_if.sink                            in_i,
  input  logic                                q_full_i,
  input  logic                                line_done_i,
  output logic                                push_o,
  output ulenc_pkg::ulenc_cmd_t               cmd_o,
  output logic                                we_o,
  output logic [$clog2(2*LINE_BYTES)-1:0]     waddr_o,
  output logic [7:0]                          wdata_o
);
  import ulenc_pkg::*;

  localparam int AW = $clog2(2*LINE_BYTES);
  localparam logic [AW-1:0] BankOfs = AW'(LINE_BYTES);

  logic [CNT_W-1:0] fill_q, fill_d, fill_n;
  logic             bank_q, bank_d;
  logic [1:0]       lines_q, lines_d;
  logic             acc, full, do_line;

  // two line banks: hold off while both are waiting on the back end
  assign in_i.ready = !q_full_i && (lines_q != 2'd2);
  assign acc        = in_i.valid && in_i.ready;

  assign fill_n  = in_i.carries_byte ? fill_q + 1'b1 : fill_q;
  assign full    = in_i.carries_byte && (fill_n == CNT_W'(LINE_BYTES));
  assign do_line = full || (in_i.end_of_message && (fill_n != '0));

  assign push_o        = acc && (do_line || in_i.end_of_message);
  assign cmd_o.do_line = do_line;
  assign cmd_o.bank    = bank_q;
  assign cmd_o.count   = fill_n;
  assign cmd_o.trailer = in_i.end_of_message;

  assign we_o    = acc && in_i.carries_byte;
  assign waddr_o = AW'(fill_q) + (bank_q ? BankOfs : '0);
  assign wdata_o = in_i.data_byte;

  always_comb begin
    fill_d = fill_q;
    bank_d = bank_q;
    if (acc) begin
      if (do_line) begin
        fill_d = '0;
        bank_d = !bank_q;
      end else begin
        fill_d = fill_n;
      end
    end
    lines_d = lines_q + {1'b0, acc && do_line} - {1'b0, line_done_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      bank_q  <= 1'b0;
      lines_q <= '0;
    end else begin
      fill_q  <= fill_d;
      bank_q  <= bank_d;
      lines_q <= lines_d;
    end
  end

endmodule

### hdl/ulenc_queue.sv
`timescale 1ns / 1ps
module ulenc_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  ulenc_pkg::ulenc_cmd_t push_data_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output logic                  valid_o,
  output ulenc_pkg::ulenc_cmd_t data_o
);
  import ulenc_pkg::*;

  localparam int Depth = 2;

  ulenc_cmd_t                 slot_q [Depth];
  logic [$clog2(Depth)-1:0]   wr_q, rd_q;
  logic [$clog2(Depth+1)-1:0] cnt_q;
  logic                       do_push, do_pop;

  assign full_o  = (cnt_q == ($clog2(Depth+1))'(Depth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = slot_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= rd_q + 1'b1;
      end
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= push_data_i;
    end
  end

endmodule

### hdl/ulenc_back.sv
`timescale 1ns / 1ps
module ulenc_back #(
  parameter int LINE_BYTES = 45
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            q_valid_i,
  input  ulenc_pkg::ulenc_cmd_t           q_data_i,
  output logic                            q_pop_o,
  output logic                            line_done_o,
  output logic                            re_o,
  output logic [$clog2(2*LINE_BYTES)-1:0] raddr_o,
  input  logic [7:0]                      rdata_i,
  ulenc_out_if.source                     out_o
);
  import ulenc_pkg::*;

  localparam int AW = $clog2(2*LINE_BYTES);
  localparam logic [AW-1:0] BankOfs = AW'(LINE_BYTES);

  bk_state_e        state_q, state_d;
  ulenc_cmd_t       ent_q, ent_d;
  logic [CNT_W-1:0] grp_q, grp_d, idx;
  logic [1:0]       k_q, k_d;
  logic             rd_ok_q;
  logic [7:0]       b0_q, b1_q, b2_q, rbyte;
  logic             slot_free, emit, ch_last, ch_done;
  logic [6:0]       ch;
  logic             out_valid_q;
  logic [6:0]       out_char_q;
  logic             out_last_q, out_done_q;

  assign slot_free = !out_valid_q || out_o.ready;
  assign idx       = grp_q + CNT_W'(k_q);
  assign rbyte     = rd_ok_q ? rdata_i : 8'd0;
  assign raddr_o   = AW'(idx) + (ent_q.bank ? BankOfs : '0);

  always_comb begin
    state_d     = state_q;
    ent_d       = ent_q;
    grp_d       = grp_q;
    k_d         = k_q;
    q_pop_o     = 1'b0;
    line_done_o = 1'b0;
    re_o        = 1'b0;
    emit        = 1'b0;
    ch          = CH_NL;
    ch_last     = 1'b0;
    ch_done     = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          ent_d   = q_data_i;
          grp_d   = '0;
          state_d = q_data_i.do_line ? BK_LEN : BK_TQ;
        end
      end
      BK_LEN: begin
        ch = enc6(ent_q.count);
        if (slot_free) begin
          emit    = 1'b1;
          k_d     = '0;
          state_d = BK_FETCH;
        end
      end
      BK_FETCH: begin
        re_o = (k_q != 2'd3) && (idx < ent_q.count);
        k_d  = k_q + 1'b1;
        if (k_q == 2'd3) begin
          state_d = BK_EMIT;
        end
      end
      BK_EMIT: begin
        unique case (k_q)
          2'd0: ch = enc6(b0_q[7:2]);
          2'd1: ch = enc6({b0_q[1:0], b1_q[7:4]});
          2'd2: ch = enc6({b1_q[3:0], b2_q[7:6]});
          default: ch = enc6(b2_q[5:0]);
        endcase
        if (slot_free) begin
          emit = 1'b1;
          k_d  = k_q + 1'b1;
          if (k_q == 2'd3) begin
            grp_d   = grp_q + CNT_W'(3);
            state_d = (grp_q + CNT_W'(3) < ent_q.count) ? BK_FETCH : BK_NL;
          end
        end
      end
      BK_NL: begin
        ch      = CH_NL;
        ch_last = !ent_q.trailer;
        if (slot_free) begin
          emit        = 1'b1;
          line_done_o = 1'b1;
          state_d     = ent_q.trailer ? BK_TQ : BK_IDLE;
        end
      end
      BK_TQ: begin
        ch = CH_BQ;
        if (slot_free) begin
          emit    = 1'b1;
          state_d = BK_TNL;
        end
      end
      BK_TNL: begin
        ch      = CH_NL;
        ch_last = 1'b1;
        ch_done = 1'b1;
        if (slot_free) begin
          emit    = 1'b1;
          state_d = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      grp_q       <= '0;
      k_q         <= '0;
      rd_ok_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      grp_q   <= grp_d;
      k_q     <= k_d;
      rd_ok_q <= re_o;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
    if (state_q == BK_FETCH) begin
      unique case (k_q)
        2'd1: b0_q <= rbyte;
        2'd2: b1_q <= rbyte;
        2'd3: b2_q <= rbyte;
        default: ;
      endcase
    end
    if (emit) begin
      out_char_q <= ch;
      out_last_q <= ch_last;
      out_done_q <= ch_done;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.out_char     = out_char_q;
  assign out_o.last_of_run  = out_last_q;
  assign out_o.message_done = out_done_q;

endmodule

### hdl/uuencode_line_encoder_unit.sv
// The first character of a transaction passes the command queue, the back end's idle and length
// states and the output register before it is valid, when the back end is idle and the output register is free.
// Each line sends a length character, then for each 3-byte group fetches 3 RAM bytes and emits
// 4 characters, and ends with a newline; fetch and emit do not overlap.
// Two line banks and a 2-entry command queue let intake run ahead of the back end.
// Reset (rst_ni, async, active low) clears all control state; line RAM is not cleared.
`timescale 1ns / 1ps
module uuencode_line_encoder_unit #(
  parameter int LINE_BYTES = 45
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ulenc_in_if.sink    in_i,
  ulenc_out_if.source out_o
);
  import ulenc_pkg::*;

  localparam int AW = $clog2(2*LINE_BYTES);

  ulenc_cmd_t    push_cmd, q_cmd;
  logic          push, q_full, q_valid, q_pop, line_done;
  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    wdata, rdata;

  ulenc_front #(.LINE_BYTES(LINE_BYTES)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .q_full_i    (q_full),
    .line_done_i (line_done),
    .push_o      (push),
    .cmd_o       (push_cmd),
    .we_o        (we),
    .waddr_o     (waddr),
    .wdata_o     (wdata)
  );

  ulenc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .data_o      (q_cmd)
  );

  ulenc_ram #(.WIDTH(8), .DEPTH(2*LINE_BYTES)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  ulenc_back #(.LINE_BYTES(LINE_BYTES)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_cmd),
    .q_pop_o     (q_pop),
    .line_done_o (line_done),
    .re_o        (re),
    .raddr_o     (raddr),
    .rdata_i     (rdata),
    .out_o       (out_o)
  );

endmodule

### hdl/ulenc_checker.sv
`timescale 1ns / 1ps
`include "uuencode_line_encoder_unit_assert.svh"
module ulenc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [6:0] out_char_i,
  input logic       out_last_i,
  input logic       out_done_i
);
  import ulenc_pkg::*;

  `ULENC_ASSERT_NOW(a_done_is_last, out_valid_i && out_done_i, out_last_i)
  `ULENC_ASSERT_NOW(a_done_is_nl, out_valid_i && out_done_i, out_char_i == CH_NL)
  `ULENC_ASSERT_NOW(a_char_set, out_valid_i, (out_char_i == CH_NL) || ((out_char_i >= CH_SPACE) && (out_char_i <= CH_BQ)))
  `ULENC_ASSERT_NEXT(a_stall_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_char_i))

endmodule

bind uuencode_line_encoder_unit ulenc_checker u_ulenc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_char_i  (out_o.out_char),
  .out_last_i  (out_o.last_of_run),
  .out_done_i  (out_o.message_done)
);
